@@ rtl/pie_pkg.sv @@
`timescale 1ns / 1ps

package pie_pkg;

	localparam int CMD_W   = 2;
	localparam int POS_W   = 7;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_ERASE  = 2'd1,
		CMD_READ   = 2'd2
	} cmd_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} stat_code_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_INS  = 6'b000010,
		S_DEL  = 6'b000100,
		S_SHW  = 6'b001000,
		S_RD   = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic rd_src;
		logic rd_pos;
		logic wr_value;
		logic wr_shift;
		logic cnt_inc;
		logic cnt_dec;
		logic load_res;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic ins_go;
		logic del_go;
		logic rd_go;
		logic at_end;
		logic dir_erase;
		logic res_free;
	} sts_t;

endpackage

@@ rtl/pie_ctrl.sv @@
`timescale 1ns / 1ps

module pie_ctrl import pie_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					priority if (sts.ins_go) begin
						state_d = S_INS;
					end else if (sts.del_go) begin
						state_d = S_DEL;
					end else if (sts.rd_go) begin
						state_d = S_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_INS: begin
				if (sts.at_end) begin
					ctl.wr_value = 1'b1;
					ctl.cnt_inc  = 1'b1;
					state_d      = S_DONE;
				end else begin
					ctl.rd_src = 1'b1;
					state_d    = S_SHW;
				end
			end
			S_DEL: begin
				if (sts.at_end) begin
					ctl.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					ctl.rd_src = 1'b1;
					state_d    = S_SHW;
				end
			end
			S_SHW: begin
				ctl.wr_shift = 1'b1;
				state_d      = sts.dir_erase ? S_DEL : S_INS;
			end
			S_RD: begin
				ctl.rd_pos = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.res_free) begin
					ctl.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/pie_dpath.sv @@
`timescale 1ns / 1ps

module pie_dpath import pie_pkg::*; #(
	parameter int CAPACITY  = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctl_t                      ctl,
	output sts_t                      sts,
	input  logic [CMD_W-1:0]          cmd,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] read_value,
	output logic [COUNT_W-1:0]        entry_count,
	output logic [STAT_W-1:0]         status
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	logic [WORD_BITS-1:0] mem [CAPACITY];

	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     pos_q;
	logic [WORD_BITS-1:0] val_q;
	logic                 dir_q;
	logic                 rd_ok_q;
	stat_code_t           stat_q;
	logic [WORD_BITS-1:0] rdata_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] res_value_q;
	logic [COUNT_W-1:0]        res_count_q;
	stat_code_t                res_stat_q;

	logic [CMP_W-1:0]     count_w;
	logic [CMP_W-1:0]     pos_w;
	logic                 full;
	stat_code_t           stat_in;
	logic [IDX_W-1:0]     ins_pos;
	logic [IDX_W-1:0]     src_idx;
	logic [IDX_W-1:0]     raddr;
	logic                 re;
	logic                 we;
	logic [WORD_BITS-1:0] wdata;
	logic [63:0]          val_ext;
	logic signed [63:0]   rd_ext;

	assign count_w = CMP_W'(count_q);
	assign pos_w   = CMP_W'(position);
	assign full    = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		stat_in = ST_DONE;
		unique case (cmd)
			CMD_INSERT: begin
				priority if (full) begin
					stat_in = ST_FULL;
				end else if (pos_w > count_w + CMP_W'(1)) begin
					stat_in = ST_RANGE;
				end else begin
					stat_in = ST_DONE;
				end
			end
			CMD_ERASE, CMD_READ: begin
				stat_in = (pos_w >= count_w) ? ST_RANGE : ST_DONE;
			end
			default: begin
				stat_in = ST_RANGE;
			end
		endcase
	end

	assign ins_pos = (pos_w > count_w) ? IDX_W'(count_q) : IDX_W'(position);

	assign sts.ins_go    = (cmd == CMD_INSERT) && (stat_in == ST_DONE);
	assign sts.del_go    = (cmd == CMD_ERASE) && (stat_in == ST_DONE);
	assign sts.rd_go     = (cmd == CMD_READ) && (stat_in == ST_DONE);
	assign sts.dir_erase = dir_q;
	assign sts.at_end    = dir_q ? ((CNT_W'(idx_q) + CNT_W'(1)) >= count_q)
	                             : (idx_q == pos_q);
	assign sts.res_free  = !out_valid_q || !out_stall;

	assign val_ext = {{32{value[VALUE_W-1]}}, value};

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			dir_q   <= (cmd == CMD_ERASE);
			rd_ok_q <= sts.rd_go;
			stat_q  <= stat_in;
			val_q   <= val_ext[WORD_BITS-1:0];
			if (cmd == CMD_INSERT) begin
				pos_q <= ins_pos;
				idx_q <= IDX_W'(count_q);
			end else begin
				pos_q <= IDX_W'(position);
				idx_q <= IDX_W'(position);
			end
		end else if (ctl.wr_shift) begin
			idx_q <= dir_q ? (idx_q + IDX_W'(1)) : (idx_q - IDX_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.cnt_inc) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.cnt_dec) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign src_idx = dir_q ? (idx_q + IDX_W'(1)) : (idx_q - IDX_W'(1));
	assign raddr   = ctl.rd_pos ? pos_q : src_idx;
	assign re      = ctl.rd_pos | ctl.rd_src;
	assign we      = ctl.wr_value | ctl.wr_shift;
	assign wdata   = ctl.wr_value ? val_q : rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rd_ext = 64'($signed(rdata_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_res) begin
			res_value_q <= rd_ok_q ? rd_ext[VALUE_W-1:0] : '0;
			res_count_q <= COUNT_W'(count_q);
			res_stat_q  <= stat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = res_value_q;
	assign entry_count = res_count_q;
	assign status      = res_stat_q;

endmodule

@@ rtl/positional_insert_erase_array_unit.sv @@
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_stall  | cmd, position, value
// out     | out_valid / out_stall | read_value, entry_count, status
//
// One item at a time; an insert or erase moves one entry at a time
// through the entry RAM (a read in INS or DEL, then a write in SHW).
// A read passes IDLE, RD, DONE; a rejected command goes from IDLE to DONE.
// Next item is taken while a result waits.
// Reset clears the count and the result valid; entries are not cleared.
// out_stall only holds the result register; a new result waits in DONE.

module positional_insert_erase_array_unit import pie_pkg::*; #(
	parameter int CAPACITY  = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [CMD_W-1:0]          cmd,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] read_value,
	output logic [COUNT_W-1:0]        entry_count,
	output logic [STAT_W-1:0]         status
);

	ctl_t ctl;
	sts_t sts;

	pie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	pie_dpath #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.entry_count (entry_count),
		.status      (status)
	);

endmodule

@@ tb/sv/tb_positional_insert_erase_array_unit.sv @@
`timescale 1ns / 1ps

module tb_positional_insert_erase_array_unit;
	import pie_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int ITEM_COUNT   = 1800;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int DRAIN_CYCLES = 300;

	// cmd 3 has no meaning; the block must reject it
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;
	typedef enum int {SM_NONE, SM_LIGHT, SM_HEAVY, SM_PULSE} stall_mode_t;

	typedef struct packed {
		logic [CMD_W-1:0]   op;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] val;
	} array_cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0] count;
		logic [STAT_W-1:0]  status;
	} array_report_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic [CMD_W-1:0]          cmd       = '0;
	logic [POS_W-1:0]          position  = '0;
	logic signed [VALUE_W-1:0] value     = '0;
	logic                      out_stall = 1'b0;
	logic                      in_stall;
	logic                      out_valid;
	logic signed [VALUE_W-1:0] read_value;
	logic [COUNT_W-1:0]        entry_count;
	logic [STAT_W-1:0]         status;

	array_cmd_t    cmd_q[$];
	array_report_t report_q[$];

	logic [VALUE_W-1:0] model_words [CAPACITY];
	int                 model_count = 0;
	int                 shadow_count = 0;
	int                 error_count = 0;
	int                 cycle_count = 0;

	always #1 clk = ~clk;

	positional_insert_erase_array_unit #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (32)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.entry_count (entry_count),
		.status      (status)
	);

	// expected outcome of one command on the array image
	function automatic array_report_t array_apply(array_cmd_t c);
		array_report_t r;
		int            p;
		int            i;
		r.read_value = '0;
		r.status     = ST_DONE;
		p            = int'(c.pos);
		case (c.op)
			CMD_INSERT: begin
				if (model_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (p > model_count + 1) begin
					r.status = ST_RANGE;
				end else begin
					if (p > model_count)
						p = model_count;
					for (i = model_count; i > p; i--)
						model_words[i] = model_words[i-1];
					model_words[p] = c.val;
					model_count++;
				end
			end
			CMD_ERASE: begin
				if (p >= model_count) begin
					r.status = ST_RANGE;
				end else begin
					for (i = p; i + 1 < model_count; i++)
						model_words[i] = model_words[i+1];
					model_count--;
				end
			end
			CMD_READ: begin
				if (p >= model_count)
					r.status = ST_RANGE;
				else
					r.read_value = model_words[p];
			end
			default: r.status = ST_RANGE;
		endcase
		r.count = COUNT_W'(model_count);
		return r;
	endfunction

	// queue a command, tracking the count it leaves so positions can aim at valid slots
	task automatic queue_cmd(logic [CMD_W-1:0] op, int pos, logic [VALUE_W-1:0] val);
		array_cmd_t c;
		c.op  = op;
		c.pos = POS_W'(pos);
		c.val = val;
		cmd_q.push_back(c);
		if (op == CMD_INSERT && shadow_count < CAPACITY && pos <= shadow_count + 1)
			shadow_count++;
		else if (op == CMD_ERASE && pos < shadow_count)
			shadow_count--;
	endtask

	// driver: bursts of items separated by random gaps
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		array_cmd_t nxt;
		logic       load;
		logic       end_burst;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			load      = 1'b0;
			end_burst = 1'b0;
			if (in_valid && !in_stall) begin
				report_q.push_back(array_apply(array_cmd_t'({cmd, position, value})));
				if (burst_left > 0 && cmd_q.size() > 0)
					load = 1'b1;
				else
					end_burst = 1'b1;
			end else if (!in_valid) begin
				if (gap_left > 0)
					gap_left--;
				else if (cmd_q.size() > 0)
					load = 1'b1;
			end
			if (end_burst) begin
				if ($urandom_range(0, 4) == 0) begin
					burst_left = $urandom_range(30, 100);
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(1, 8);
					gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
						: $urandom_range(0, 5);
				end
			end
			if (load) begin
				nxt = cmd_q.pop_front();
				burst_left--;
				cmd      <= nxt.op;
				position <= nxt.pos;
				value    <= nxt.val;
				in_valid <= 1'b1;
			end else if (!in_valid || !in_stall) begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each result, stalls on its own pattern
	stall_mode_t stall_mode = SM_NONE;
	int          stall_span = 0;
	int          stall_tick = 0;

	always @(posedge clk or negedge arst_n) begin
		array_report_t want;
		logic          s;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (report_q.size() == 0) begin
					$display("%0t unexpected result: read_value %0d entry_count %0d status %0d",
						$time, read_value, entry_count, status);
					error_count++;
				end else begin
					want = report_q.pop_front();
					if (read_value !== want.read_value) begin
						$display("%0t read_value: expected %0d, actual %0d",
							$time, $signed(want.read_value), read_value);
						error_count++;
					end
					if (entry_count !== want.count) begin
						$display("%0t entry_count: expected %0d, actual %0d",
							$time, want.count, entry_count);
						error_count++;
					end
					if (status !== want.status) begin
						$display("%0t status: expected %0d, actual %0d",
							$time, want.status, status);
						error_count++;
					end
				end
			end
			if (stall_span <= 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_span = $urandom_range(20, 300);
			end
			stall_span--;
			stall_tick++;
			case (stall_mode)
				SM_LIGHT: s = ($urandom_range(0, 3) == 0);
				SM_HEAVY: s = ($urandom_range(0, 3) != 0);
				SM_PULSE: s = (stall_tick % 5) < 2;
				default:  s = 1'b0;
			endcase
			out_stall <= s;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		phase_t             ph;
		int                 span;
		int                 roll;
		int                 n;
		int                 pos;
		logic [CMD_W-1:0]   op;
		logic [VALUE_W-1:0] val;

		// empty array, appends at count and count + 1, front and middle inserts
		queue_cmd(CMD_READ,   0,   32'h0000_0000);
		queue_cmd(CMD_ERASE,  0,   32'h0000_0000);
		queue_cmd(CMD_INSERT, 1,   32'h7FFF_FFFF);
		queue_cmd(CMD_INSERT, 1,   32'h8000_0000);
		queue_cmd(CMD_INSERT, 0,   32'h0000_0000);
		queue_cmd(CMD_INSERT, 2,   32'hFFFF_FFFF);
		queue_cmd(CMD_INSERT, 5,   32'h5555_5555);
		// insert past the end
		queue_cmd(CMD_INSERT, 7,   32'h1234_5678);
		queue_cmd(CMD_INSERT, 127, 32'hAAAA_AAAA);
		queue_cmd(CMD_READ,   0,   32'h0000_0000);
		queue_cmd(CMD_READ,   4,   32'h0000_0000);
		queue_cmd(CMD_READ,   5,   32'h0000_0000);
		queue_cmd(CMD_READ,   127, 32'h0000_0000);
		queue_cmd(CMD_UNUSED, 0,   32'hFFFF_FFFF);
		// erase last, first, middle, then out of range
		queue_cmd(CMD_ERASE,  4,   32'h0000_0000);
		queue_cmd(CMD_ERASE,  0,   32'h0000_0000);
		queue_cmd(CMD_ERASE,  1,   32'h0000_0000);
		queue_cmd(CMD_ERASE,  2,   32'h0000_0000);
		queue_cmd(CMD_ERASE,  127, 32'h0000_0000);
		queue_cmd(CMD_READ,   1,   32'h0000_0000);
		queue_cmd(CMD_READ,   0,   32'h0000_0000);
		queue_cmd(CMD_INSERT, 64,  32'hAAAA_AAAA);

		// random part: phases that fill to full, drain to empty, or mix
		ph   = PH_FILL;
		span = 200;
		for (n = 0; n < ITEM_COUNT; n++) begin
			if (span == 0) begin
				ph   = phase_t'($urandom_range(0, 2));
				span = $urandom_range(40, 200);
			end
			span--;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = CMD_UNUSED;
			else case (ph)
				PH_FILL:  op = (roll < 85) ? CMD_INSERT : (roll < 92) ? CMD_ERASE : CMD_READ;
				PH_DRAIN: op = (roll < 15) ? CMD_INSERT : (roll < 85) ? CMD_ERASE : CMD_READ;
				default:  op = (roll < 38) ? CMD_INSERT : (roll < 68) ? CMD_ERASE : CMD_READ;
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 12)
				pos = $urandom_range(0, 127);
			else if (roll < 22)
				pos = shadow_count + $urandom_range(0, 2) - 1;
			else if (op == CMD_INSERT)
				pos = $urandom_range(0, shadow_count + 1);
			else
				pos = (shadow_count == 0) ? 0 : $urandom_range(0, shadow_count - 1);
			if (pos < 0)
				pos = 0;
			case ($urandom_range(0, 7))
				0:       val = 32'h7FFF_FFFF;
				1:       val = 32'h8000_0000;
				2:       val = 32'h0000_0000;
				3:       val = 32'hFFFF_FFFF;
				default: val = $urandom;
			endcase
			queue_cmd(op, pos, val);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || in_valid || report_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
